/* sv/mtb_pkg.sv */
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, codes and types for the timer bank front and back ends.
// ----------------------------------------------------------------------------
package mtb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_BITS  = 4;
  localparam int IDX_BITS   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MAX_OUT    = 16;
  localparam int CNT_BITS   = 5;
  localparam int SHOT_BITS  = 17;

  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_CREATE_P  = 4'd1,
    CMD_CREATE_O  = 4'd2,
    CMD_CREATE_N  = 4'd3,
    CMD_SET_DELAY = 4'd4,
    CMD_SET_SHOTS = 4'd5,
    CMD_GET_REM   = 4'd6,
    CMD_REMOVE    = 4'd7,
    CMD_RESET     = 4'd8,
    CMD_PAUSE     = 4'd9,
    CMD_START     = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [3:0]           cmd;
    logic                 inrange;
    logic [IDX_BITS-1:0]  idx;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] delay;
    logic [15:0]          shots;
    logic [15:0]          id;
  } job_t;

endpackage

/* sv/mtb_front.sv */
// ----------------------------------------------------------------------------
// Timer bank front end
// Accepts items, classifies the slot and queues them for the back end.
// ----------------------------------------------------------------------------
module mtb_front import mtb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [3:0]           cmd_i,
  input  logic [3:0]           slot_i,
  input  logic [TIME_BITS-1:0] now_ms_i,
  input  logic [TIME_BITS-1:0] delay_ms_i,
  input  logic [15:0]          shot_count_i,
  input  logic [15:0]          timer_id_i,
  output logic                 job_valid_o,
  input  logic                 job_take_i,
  output job_t                 job_o
);

  job_t q_mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  job_t nj;

  always_comb begin
    nj.cmd     = cmd_i;
    nj.inrange = ({28'd0, slot_i} < NUM_TIMERS);
    nj.idx     = IDX_BITS'(slot_i);
    nj.now     = now_ms_i;
    nj.delay   = delay_ms_i;
    nj.shots   = shot_count_i;
    nj.id      = timer_id_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_take_i && job_valid_o;
  assign job_o       = q_mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= nj;
  end

endmodule

/* sv/mtb_back.sv */
// ----------------------------------------------------------------------------
// Timer bank back end
// Holds the timer slots, executes commands and scans slots on a tick.
// ----------------------------------------------------------------------------
module mtb_back import mtb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_take_o,
  input  job_t                  job_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic                  ok_o,
  output logic [15:0]           fired_id_o,
  output logic signed [16:0]    remaining_shots_o,
  output logic [CNT_BITS-1:0]   fired_count_o,
  output logic                  last_o
);

  logic [NUM_TIMERS-1:0] used_q, running_q, periodic_q, counted_q;
  logic signed [SHOT_BITS-1:0] shots_q [NUM_TIMERS];
  logic [15:0]           ident_q [NUM_TIMERS];
  logic [TIME_BITS-1:0]  delay_q [NUM_TIMERS];
  logic [TIME_BITS-1:0]  dl_q    [NUM_TIMERS];

  state_e state_q, state_d;
  job_t   job_q;
  logic [IDX_BITS-1:0]   sc_q;
  logic [CNT_BITS-1:0]   n_q;

  logic                  sv_q;
  logic [15:0]           sid_q;
  logic signed [SHOT_BITS-1:0] ssh_q;
  logic [CNT_BITS-1:0]   scnt_q;

  logic                  ov_q, ov_d;
  logic                  okind_q, ook_q, olast_q;
  logic [15:0]           oid_q;
  logic signed [SHOT_BITS-1:0] osh_q;
  logic [CNT_BITS-1:0]   ocnt_q;

  logic                  ofree;
  logic                  hit, fire, advance, last_slot, scan_end;
  logic                  push_stage, flush, cmd_out;
  logic                  is_create, rep_ok, reload, dec;
  logic [TIME_BITS-1:0]  diff;
  logic signed [SHOT_BITS-1:0] shots_ext, fire_sh, rep_sh;

  assign ofree     = !ov_q || !out_stall_i;
  assign diff      = job_q.now - dl_q[sc_q];
  assign hit       = used_q[sc_q] && running_q[sc_q] && !diff[TIME_BITS-1];
  assign last_slot = (sc_q == IDX_BITS'(NUM_TIMERS - 1));
  assign shots_ext = $signed({1'b0, job_q.shots}) - 17'sd1;

  assign reload  = periodic_q[sc_q] || (counted_q[sc_q] && shots_q[sc_q] > 17'sd0);
  assign dec     = !periodic_q[sc_q] && counted_q[sc_q] && shots_q[sc_q] > 17'sd0;
  assign fire_sh = dec ? shots_q[sc_q] - 17'sd1 : shots_q[sc_q];

  assign is_create = (job_q.cmd == CMD_CREATE_P) || (job_q.cmd == CMD_CREATE_O) ||
                     (job_q.cmd == CMD_CREATE_N);
  assign rep_ok    = is_create ? job_q.inrange :
                     (job_q.inrange && used_q[job_q.idx] && job_q.cmd <= CMD_START);
  assign rep_sh    = (rep_ok && job_q.cmd == CMD_GET_REM) ? shots_q[job_q.idx] : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) state_d = (job_i.cmd == CMD_TICK) ? ST_SCAN : ST_CMD;
      end
      ST_CMD: begin
        if (ofree) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_end) state_d = (sv_q || fire) ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (ofree) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_take_o = (state_q == ST_IDLE) && job_valid_i;
    cmd_out    = (state_q == ST_CMD) && ofree;
    fire       = (state_q == ST_SCAN) && hit && (!sv_q || ofree);
    advance    = (state_q == ST_SCAN) && (!hit || fire);
    push_stage = fire && sv_q;
    flush      = (state_q == ST_FLUSH) && ofree;
    scan_end   = advance && (last_slot || (fire && n_q == CNT_BITS'(MAX_OUT - 1)));
  end

  always_comb begin
    ov_d = (ov_q && out_stall_i) || cmd_out || push_stage || flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      ov_q    <= 1'b0;
      sc_q    <= '0;
      n_q     <= '0;
      sv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (fire) sv_q <= 1'b1;
      else if (flush) sv_q <= 1'b0;
      if (job_take_o) begin
        sc_q <= '0;
        n_q  <= '0;
      end else if (advance) begin
        sc_q <= sc_q + IDX_BITS'(1);
        n_q  <= n_q + {{(CNT_BITS-1){1'b0}}, fire};
      end
      if (cmd_out && job_q.inrange) begin
        if (is_create) begin
          used_q[job_q.idx] <= 1'b1;
        end else if (job_q.cmd == CMD_REMOVE) begin
          used_q[job_q.idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) job_q <= job_i;
    if (cmd_out) begin
      okind_q <= 1'b0;
      ook_q   <= rep_ok;
      oid_q   <= '0;
      osh_q   <= rep_sh;
      ocnt_q  <= '0;
      olast_q <= 1'b1;
    end else if (push_stage || flush) begin
      okind_q <= 1'b1;
      ook_q   <= 1'b1;
      oid_q   <= sid_q;
      osh_q   <= ssh_q;
      ocnt_q  <= scnt_q;
      olast_q <= flush;
    end
    if (fire) begin
      sid_q  <= ident_q[sc_q];
      ssh_q  <= fire_sh;
      scnt_q <= n_q + CNT_BITS'(1);
    end
    if (cmd_out && job_q.inrange && is_create) begin
      running_q[job_q.idx]  <= 1'b1;
      periodic_q[job_q.idx] <= (job_q.cmd == CMD_CREATE_P);
      counted_q[job_q.idx]  <= (job_q.cmd == CMD_CREATE_N);
      shots_q[job_q.idx]    <= (job_q.cmd == CMD_CREATE_N) ? shots_ext : '0;
      ident_q[job_q.idx]    <= job_q.id;
      delay_q[job_q.idx]    <= job_q.delay;
      dl_q[job_q.idx]       <= job_q.now + job_q.delay;
    end else if (cmd_out && rep_ok) begin
      case (job_q.cmd)
        CMD_SET_DELAY: delay_q[job_q.idx] <= job_q.delay;
        CMD_SET_SHOTS: shots_q[job_q.idx] <= shots_ext;
        CMD_RESET:     dl_q[job_q.idx] <= job_q.now + delay_q[job_q.idx];
        CMD_PAUSE:     running_q[job_q.idx] <= 1'b0;
        CMD_START: begin
          dl_q[job_q.idx]      <= job_q.now + delay_q[job_q.idx];
          running_q[job_q.idx] <= 1'b1;
        end
        default: ;
      endcase
    end else if (fire) begin
      if (reload) dl_q[sc_q] <= dl_q[sc_q] + delay_q[sc_q];
      if (dec) shots_q[sc_q] <= fire_sh;
      if (!reload) running_q[sc_q] <= 1'b0;
    end
  end

  assign out_valid_o       = ov_q;
  assign kind_o            = okind_q;
  assign ok_o              = ook_q;
  assign fired_id_o        = oid_q;
  assign remaining_shots_o = osh_q;
  assign fired_count_o     = ocnt_q;
  assign last_o            = olast_q;

endmodule

/* sv/multi_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// Timer bank top level
// Sixteen software timers; commands reply once, ticks emit fire notices.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in       | in_valid_i/in_stall_o| cmd, slot, now_ms, delay_ms, shot_count, timer_id
//  out      | out_valid_o/out_stall_i | kind, ok, fired_id, remaining_shots, fired_count, last
//
// A command passes the command state and replies once the output is free. A tick
// visits the slots in order, one per cycle unless a stall holds a staged notice, and
// a flush state releases the final notice when any timer fired. Each notice waits
// in a stage until the next. Reset empties every slot and the two-entry item queue.
// A stalled output holds the back end; the queue keeps accepting until full.
module multi_timer_bank_unit import mtb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [3:0]           cmd_i,
  input  logic [3:0]           slot_i,
  input  logic [TIME_BITS-1:0] now_ms_i,
  input  logic [TIME_BITS-1:0] delay_ms_i,
  input  logic [15:0]          shot_count_i,
  input  logic [15:0]          timer_id_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 kind_o,
  output logic                 ok_o,
  output logic [15:0]          fired_id_o,
  output logic signed [16:0]   remaining_shots_o,
  output logic [CNT_BITS-1:0]  fired_count_o,
  output logic                 last_o
);

  logic job_valid, job_take;
  job_t job;

  mtb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .slot_i, .now_ms_i,
    .delay_ms_i, .shot_count_i, .timer_id_i,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  mtb_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .out_valid_o, .out_stall_i, .kind_o, .ok_o, .fired_id_o, .remaining_shots_o,
    .fired_count_o, .last_o
  );

endmodule

/* sv/mtb_checker.sv */
// ----------------------------------------------------------------------------
// Timer bank port checker
// Watches the top-level ports for output hold and field rules.
// ----------------------------------------------------------------------------
module mtb_checker import mtb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                kind_o,
  input logic                ok_o,
  input logic [15:0]         fired_id_o,
  input logic [CNT_BITS-1:0] fired_count_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fired_id_o))
    else $error("stalled item changed");

  a_notice_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> ok_o && fired_count_o != '0)
    else $error("fire notice without count");

  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> fired_count_o == '0 && fired_id_o == '0)
    else $error("reply with notice fields");

endmodule

bind multi_timer_bank_unit mtb_checker u_mtb_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .kind_o, .ok_o, .fired_id_o,
  .fired_count_o
);
